// ===== rtl/auto_gain_range_stepper_macros.svh =====
// assertion macros shared by the auto gain range stepper rtl
// no dependencies
`ifndef AUTO_GAIN_RANGE_STEPPER_MACROS_SVH
`define AUTO_GAIN_RANGE_STEPPER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AGRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AGRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/agrs_pkg.sv =====
// types and constants of the auto gain range stepper
// no dependencies
package agrs_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int KEY_W     = 8;
    localparam int LEVEL_W   = 4;
    localparam int HOLDOFF_W = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 10;

    localparam logic [SAMPLE_W-1:0] HALF_SCALE_COUNT = 10'd511;
    localparam logic [LEVEL_W-1:0]  LEVEL_MIN        = 4'd1;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX        = 4'd15;

    localparam logic [SAMPLE_W-1:0]  HIGH_LIMIT_RESET = 10'd649;
    localparam logic [SAMPLE_W-1:0]  LOW_LIMIT_RESET  = 10'd6;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET    = 4'd5;
    localparam logic [KEY_W-1:0]     TOGGLE_KEY_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_KEY = 4'd3;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_OFF      = 2'd0,
        ST_IN_RANGE = 2'd1,
        ST_LOWERED  = 2'd2,
        ST_RAISED   = 2'd3
    } t_status;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  high_limit_counts;
        logic [SAMPLE_W-1:0]  low_limit_counts;
        logic [HOLDOFF_W-1:0] holdoff_ticks;
        logic [KEY_W-1:0]     toggle_key;
    } t_cfg;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] adc_sample;
        logic [KEY_W-1:0]    key_value;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] gain_level;
        logic               auto_on;
        t_status            range_status;
        logic               half_scale;
    } t_out_item;

endpackage

// ===== rtl/agrs_ifs.sv =====
// channel interfaces of the auto gain range stepper
// depends on agrs_pkg
interface agrs_in_if import agrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [KEY_W-1:0]    key_value;

    modport source (output valid, action, adc_sample, key_value, input ready);
    modport sink   (input valid, action, adc_sample, key_value, output ready);
endinterface

interface agrs_out_if import agrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] gain_level;
    logic               auto_on;
    logic [1:0]         range_status;
    logic               half_scale;

    modport source (output valid, gain_level, auto_on, range_status, half_scale, input ready);
    modport sink   (input valid, gain_level, auto_on, range_status, half_scale, output ready);
endinterface

interface agrs_cfg_if import agrs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/agrs_cfg_regs.sv =====
// configuration registers of the auto gain range stepper
// depends on agrs_pkg and agrs_cfg_if
module agrs_cfg_regs
    import agrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    agrs_cfg_if.sink         i_cfg,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_limit_counts <= HIGH_LIMIT_RESET;
            r_cfg.low_limit_counts  <= LOW_LIMIT_RESET;
            r_cfg.holdoff_ticks     <= HOLDOFF_RESET;
            r_cfg.toggle_key        <= TOGGLE_KEY_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_HIGH_LIMIT: r_cfg.high_limit_counts <= i_cfg.data[SAMPLE_W-1:0];
                CFG_LOW_LIMIT:  r_cfg.low_limit_counts  <= i_cfg.data[SAMPLE_W-1:0];
                CFG_HOLDOFF:    r_cfg.holdoff_ticks     <= i_cfg.data[HOLDOFF_W-1:0];
                CFG_TOGGLE_KEY: r_cfg.toggle_key        <= i_cfg.data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/agrs_step.sv =====
// gain ranging state and its single pass update
// depends on agrs_pkg and auto_gain_range_stepper_macros.svh
`include "auto_gain_range_stepper_macros.svh"

module agrs_step
    import agrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_next
);

    logic                 r_enabled;
    logic                 r_key_latched;
    logic [HOLDOFF_W-1:0] r_holdoff;
    logic [LEVEL_W-1:0]   r_level;
    logic [SAMPLE_W-1:0]  r_last_sample;
    t_status              r_status;
    logic                 r_half;

    logic                 n_enabled;
    logic                 n_key_latched;
    logic [HOLDOFF_W-1:0] n_holdoff;
    logic [LEVEL_W-1:0]   n_level;
    logic [SAMPLE_W-1:0]  n_last_sample;
    t_status              n_status;
    logic                 n_half;
    logic                 w_key_hit;

    assign w_key_hit = (i_item.key_value == i_cfg.toggle_key);

    always_comb begin
        n_enabled     = r_enabled;
        n_key_latched = r_key_latched;
        n_holdoff     = r_holdoff;
        n_level       = r_level;
        n_last_sample = r_last_sample;
        n_status      = r_status;
        n_half        = r_half;
        if (i_item.action == ACT_SAMPLE) begin
            if (!r_key_latched && w_key_hit) begin
                n_key_latched = 1'b1;
                n_enabled     = !r_enabled;
            end else if (!w_key_hit) begin
                n_key_latched = 1'b0;
            end
            n_last_sample = i_item.adc_sample;
            n_half        = (i_item.adc_sample >= HALF_SCALE_COUNT);
            if (!n_enabled) begin
                n_status = ST_OFF;
            end
        end else if (r_enabled) begin
            if (r_holdoff != '0) begin
                n_holdoff = r_holdoff - 1'b1;
            end else begin
                if (r_last_sample >= i_cfg.high_limit_counts) begin
                    n_level  = (r_level > LEVEL_MIN) ? r_level - 1'b1 : LEVEL_MIN;
                    n_status = ST_LOWERED;
                end else if (r_last_sample < i_cfg.low_limit_counts) begin
                    n_level  = (r_level < LEVEL_MAX) ? r_level + 1'b1 : LEVEL_MAX;
                    n_status = ST_RAISED;
                end else begin
                    n_status = ST_IN_RANGE;
                end
                n_holdoff = i_cfg.holdoff_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_key_latched <= 1'b0;
            r_holdoff     <= '0;
            r_level       <= LEVEL_MIN;
            r_last_sample <= '0;
            r_status      <= ST_OFF;
            r_half        <= 1'b0;
        end else if (i_go) begin
            r_enabled     <= n_enabled;
            r_key_latched <= n_key_latched;
            r_holdoff     <= n_holdoff;
            r_level       <= n_level;
            r_last_sample <= n_last_sample;
            r_status      <= n_status;
            r_half        <= n_half;
        end
    end

    assign o_next.gain_level   = n_level;
    assign o_next.auto_on      = n_enabled;
    assign o_next.range_status = n_status;
    assign o_next.half_scale   = n_half;

    `AGRS_ASSERT_NOW(a_level_nonzero, i_clk, i_rst_n, 1'b1, r_level != '0, "gain level is zero")
    `AGRS_ASSERT_NEXT(a_tick_disabled_holds, i_clk, i_rst_n, i_go && i_item.action == ACT_TICK && !r_enabled, $stable(r_level) && $stable(r_holdoff), "tick changed state while disabled")
    `AGRS_ASSERT_NEXT(a_holdoff_counts_down, i_clk, i_rst_n, i_go && i_item.action == ACT_TICK && r_enabled && r_holdoff != '0, r_holdoff == $past(r_holdoff) - 4'd1 && $stable(r_level), "holdoff did not count down")

endmodule

// ===== rtl/auto_gain_range_stepper.sv =====
// flow: an accepted transaction waits in the input register until the output register
// can take it, then its processed result is registered there and held until taken
// throughput: one transaction per cycle unless stalled, set by single state update pass
// reset: synchronous active low, clears both stages, state and configuration to defaults
// top level of the auto gain range stepper
// depends on agrs_pkg, agrs_ifs, agrs_cfg_regs, agrs_step and the macros header
`include "auto_gain_range_stepper_macros.svh"

module auto_gain_range_stepper
    import agrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    agrs_in_if.sink    i_in,
    agrs_out_if.source o_res,
    agrs_cfg_if.sink   i_cfg
);

    t_cfg      w_cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item w_next;
    logic      w_adv;
    logic      w_go;

    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_go       = r_in_valid && w_adv;
    assign i_in.ready = w_adv || !r_in_valid;

    agrs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    agrs_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.action     <= i_in.action;
            r_in_item.adc_sample <= i_in.adc_sample;
            r_in_item.key_value  <= i_in.key_value;
        end
        if (w_go) begin
            r_out <= w_next;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.gain_level   = r_out.gain_level;
    assign o_res.auto_on      = r_out.auto_on;
    assign o_res.range_status = r_out.range_status;
    assign o_res.half_scale   = r_out.half_scale;

    `AGRS_ASSERT_NEXT(a_stall_keeps_item, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_res.ready, r_in_valid && $stable(r_in_item),
        "pending transaction lost under stall")
    `AGRS_ASSERT_NEXT(a_result_follows_go, i_clk, i_rst_n,
        w_go, r_out_valid,
        "processed transaction produced no result")
    `AGRS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        r_out_valid && !o_res.ready, r_out_valid && $stable(r_out),
        "result changed under stall")

endmodule
